@@ rtl/vswd_pkg.sv @@
// Shared types and constants for the vertex skin weight decoder.
// No dependencies; used by every module of the block but vswd_recip.
package vswd_pkg;

  localparam int WEIGHT_FRAC_BITS_DEF = 16;
  localparam int WEIGHT_BITS          = 5;
  localparam int NUM_LANES            = 3;
  localparam int STRIDE_RECIP_BITS    = 16;
  localparam int STRIDE_RECIP_W       = STRIDE_RECIP_BITS + 1;
  localparam int FRAC_W               = 17;
  localparam int ADDR_W               = 4;
  localparam int DATA_W               = 32;

  localparam logic [FRAC_W-1:0] FRAC_MAX = {FRAC_W{1'b1}};

  localparam logic [7:0] JOINT_LIMIT_RST  = 8'd0;
  localparam logic [6:0] WEIGHT_TOTAL_RST = 7'd31;
  localparam logic [7:0] ROW_STRIDE_RST   = 8'd3;

  localparam logic [STRIDE_RECIP_W-1:0] STRIDE_RECIP_RST =
    STRIDE_RECIP_W'((32'd1 << STRIDE_RECIP_BITS) / 32'(ROW_STRIDE_RST));

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_SUM      = 3'd1,
    ST_MISALIGN = 3'd2,
    ST_RANGE    = 3'd3,
    ST_DUP      = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    REG_JOINT_LIMIT  = 2'd0,
    REG_WEIGHT_TOTAL = 2'd1,
    REG_ROW_STRIDE   = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    RCP_IDLE,
    RCP_STRIDE,
    RCP_TOTAL
  } rcp_state_e;

  typedef struct packed {
    logic [7:0]  blend_index_1;
    logic [7:0]  blend_index_2;
    logic [7:0]  blend_index_3;
    logic [15:0] packed_word;
  } in_t;

  typedef struct packed {
    status_e     status;
    logic        strip_restart;
    logic [1:0]  slot_count;
    logic [7:0]  bone_0;
    logic [7:0]  bone_1;
    logic [7:0]  bone_2;
    logic [4:0]  qweight_0;
    logic [4:0]  qweight_1;
    logic [4:0]  qweight_2;
    logic [16:0] frac_weight_0;
    logic [16:0] frac_weight_1;
    logic [16:0] frac_weight_2;
  } out_t;

  typedef struct packed {
    logic              active;
    logic              aligned;
    logic              in_range;
    logic [7:0]        bone;
    logic [4:0]        qweight;
    logic [FRAC_W-1:0] frac;
  } lane_res_t;

endpackage

@@ rtl/vertex_skin_weight_decoder.sv @@
// The result strobe follows the accepting edge through the lane and merge registers; one item per cycle while not busy.
// A write to weight_total or row_stride holds busy while the serial reciprocal
// unit refreshes the matching reciprocal.
// Reset loads register defaults and their reciprocals; ready right after reset.
// The receiver cannot stall: each result stands for exactly one cycle.
// Depends on vswd_pkg, vswd_recip, vswd_lane and vswd_merge.
module vertex_skin_weight_decoder #(
  parameter int WEIGHT_FRAC_BITS = vswd_pkg::WEIGHT_FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  vswd_pkg::in_t               item_i,
  output logic                        result_valid_o,
  output vswd_pkg::out_t              result_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [vswd_pkg::ADDR_W-1:0] paddr,
  input  logic [vswd_pkg::DATA_W-1:0] pwdata,
  output logic [vswd_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);

  localparam int K  = WEIGHT_FRAC_BITS + 6;
  localparam int RW = K + 1;
  localparam int QW = (RW > vswd_pkg::STRIDE_RECIP_W) ? RW : vswd_pkg::STRIDE_RECIP_W;
  localparam int CW = $clog2(QW);
  localparam int WB = vswd_pkg::WEIGHT_BITS;
  localparam logic [RW-1:0] RT_RST =
    RW'((64'd1 << K) / 64'(vswd_pkg::WEIGHT_TOTAL_RST));

  logic [7:0] joint_limit_q, stride_q;
  logic [6:0] total_q;
  logic [vswd_pkg::STRIDE_RECIP_W-1:0] rs_q;
  logic [RW-1:0] rt_q;
  logic pend_s_q, pend_t_q, pend_s_d, pend_t_d;
  vswd_pkg::rcp_state_e st_q, st_d;
  logic rcp_start, rcp_done, clr_s, clr_t, ld_rs, ld_rt;
  logic [7:0] rcp_div;
  logic [CW-1:0] rcp_msb;
  logic [QW-1:0] rcp_quo;
  logic wr, accept;
  vswd_pkg::reg_idx_e widx;

  logic [2:0] v_q, sum_ok_q, topo_q;
  logic [6:0] wsum;
  logic [7:0] raw [vswd_pkg::NUM_LANES];
  logic [4:0] qin [vswd_pkg::NUM_LANES];
  vswd_pkg::lane_res_t lane_res [vswd_pkg::NUM_LANES];

  // Configuration port
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign widx   = vswd_pkg::reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      joint_limit_q <= vswd_pkg::JOINT_LIMIT_RST;
      total_q       <= vswd_pkg::WEIGHT_TOTAL_RST;
      stride_q      <= vswd_pkg::ROW_STRIDE_RST;
    end else if (wr) begin
      case (widx)
        vswd_pkg::REG_JOINT_LIMIT:  joint_limit_q <= pwdata[7:0];
        vswd_pkg::REG_WEIGHT_TOTAL: total_q       <= pwdata[6:0];
        vswd_pkg::REG_ROW_STRIDE:   stride_q      <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (widx)
      vswd_pkg::REG_JOINT_LIMIT:  prdata = 32'(joint_limit_q);
      vswd_pkg::REG_WEIGHT_TOTAL: prdata = 32'(total_q);
      vswd_pkg::REG_ROW_STRIDE:   prdata = 32'(stride_q);
      default:                    prdata = '0;
    endcase
  end

  // Reciprocal refresh
  assign pend_s_d = (wr && widx == vswd_pkg::REG_ROW_STRIDE) || (pend_s_q && !clr_s);
  assign pend_t_d = (wr && widx == vswd_pkg::REG_WEIGHT_TOTAL) || (pend_t_q && !clr_t);

  always_comb begin
    st_d      = st_q;
    rcp_start = 1'b0;
    rcp_div   = stride_q;
    rcp_msb   = CW'(vswd_pkg::STRIDE_RECIP_BITS);
    clr_s     = 1'b0;
    clr_t     = 1'b0;
    ld_rs     = 1'b0;
    ld_rt     = 1'b0;
    case (st_q)
      vswd_pkg::RCP_IDLE: begin
        if (pend_s_q) begin
          rcp_start = 1'b1;
          clr_s     = 1'b1;
          st_d      = vswd_pkg::RCP_STRIDE;
        end else if (pend_t_q) begin
          rcp_start = 1'b1;
          rcp_div   = 8'(total_q);
          rcp_msb   = CW'(K);
          clr_t     = 1'b1;
          st_d      = vswd_pkg::RCP_TOTAL;
        end
      end
      vswd_pkg::RCP_STRIDE: begin
        if (rcp_done) begin
          ld_rs = 1'b1;
          st_d  = vswd_pkg::RCP_IDLE;
        end
      end
      vswd_pkg::RCP_TOTAL: begin
        if (rcp_done) begin
          ld_rt = 1'b1;
          st_d  = vswd_pkg::RCP_IDLE;
        end
      end
      default: st_d = vswd_pkg::RCP_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= vswd_pkg::RCP_IDLE;
      pend_s_q <= 1'b0;
      pend_t_q <= 1'b0;
      rs_q     <= vswd_pkg::STRIDE_RECIP_RST;
      rt_q     <= RT_RST;
    end else begin
      st_q     <= st_d;
      pend_s_q <= pend_s_d;
      pend_t_q <= pend_t_d;
      if (ld_rs) begin
        rs_q <= rcp_quo[vswd_pkg::STRIDE_RECIP_W-1:0];
      end
      if (ld_rt) begin
        rt_q <= rcp_quo[RW-1:0];
      end
    end
  end

  vswd_recip #(
    .QW(QW)
  ) u_recip (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (rcp_start),
    .divisor_i(rcp_div),
    .msb_i    (rcp_msb),
    .done_o   (rcp_done),
    .quo_o    (rcp_quo)
  );

  assign busy   = (st_q != vswd_pkg::RCP_IDLE) || pend_s_q || pend_t_q;
  assign accept = start && !busy;

  // Item pipeline
  assign raw[0] = item_i.blend_index_1;
  assign raw[1] = item_i.blend_index_2;
  assign raw[2] = item_i.blend_index_3;
  assign qin[0] = item_i.packed_word[0*WB +: WB];
  assign qin[1] = item_i.packed_word[1*WB +: WB];
  assign qin[2] = item_i.packed_word[2*WB +: WB];
  assign wsum   = 7'(qin[0]) + 7'(qin[1]) + 7'(qin[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[1:0], accept};
    end
  end

  always_ff @(posedge clk_i) begin
    sum_ok_q <= {sum_ok_q[1:0], wsum == total_q};
    topo_q   <= {topo_q[1:0], item_i.packed_word[15]};
  end

  for (genvar l = 0; l < vswd_pkg::NUM_LANES; l++) begin : g_lane
    vswd_lane #(
      .WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS)
    ) u_lane (
      .clk_i        (clk_i),
      .raw_i        (raw[l]),
      .q_i          (qin[l]),
      .stride_i     (stride_q),
      .total_i      (total_q),
      .joint_limit_i(joint_limit_q),
      .rs_i         (rs_q),
      .rt_i         (rt_q),
      .res_o        (lane_res[l])
    );
  end

  vswd_merge u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v_q[2]),
    .sum_ok_i(sum_ok_q[2]),
    .topo_i  (topo_q[2]),
    .lane_i  (lane_res),
    .valid_o (result_valid_o),
    .result_o(result_o)
  );

endmodule

@@ rtl/vswd_recip.sv @@
// Bit-serial reciprocal unit: floor(2^n / divisor), one quotient bit per cycle.
// Depends on nothing outside this file.
module vswd_recip #(
  parameter int QW = 31
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [7:0]            divisor_i,
  input  logic [$clog2(QW)-1:0] msb_i,
  output logic                  done_o,
  output logic [QW-1:0]         quo_o
);

  localparam int CW = $clog2(QW);

  logic          run_q, done_q, first_q;
  logic [7:0]    rem_q, div_q, rem_d;
  logic [CW-1:0] cnt_q;
  logic [QW-1:0] quo_q;
  logic [8:0]    sh;
  logic          ge;

  assign sh    = {rem_q, first_q};
  assign ge    = sh >= {1'b0, div_q};
  assign rem_d = ge ? 8'(sh - {1'b0, div_q}) : sh[7:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= run_q && (cnt_q == '0);
      run_q  <= start_i || (run_q && (cnt_q != '0));
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q   <= '0;
      div_q   <= divisor_i;
      cnt_q   <= msb_i;
      first_q <= 1'b1;
      quo_q   <= '0;
    end else if (run_q) begin
      rem_q        <= rem_d;
      first_q      <= 1'b0;
      quo_q[cnt_q] <= ge;
      cnt_q        <= cnt_q - 1'b1;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

@@ rtl/vswd_lane.sv @@
// One weight component: bone index, alignment, range and Q1.F fraction.
// Depends on vswd_pkg; reciprocals come from the top level.
module vswd_lane #(
  parameter int WEIGHT_FRAC_BITS = vswd_pkg::WEIGHT_FRAC_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic [7:0]                           raw_i,
  input  logic [4:0]                           q_i,
  input  logic [7:0]                           stride_i,
  input  logic [6:0]                           total_i,
  input  logic [7:0]                           joint_limit_i,
  input  logic [vswd_pkg::STRIDE_RECIP_W-1:0]  rs_i,
  input  logic [WEIGHT_FRAC_BITS+6:0]          rt_i,
  output vswd_pkg::lane_res_t                  res_o
);

  localparam int K  = WEIGHT_FRAC_BITS + 6;
  localparam int NW = K;
  localparam int RW = K + 1;
  localparam int PW = NW + RW;
  localparam int BW = 8 + vswd_pkg::STRIDE_RECIP_W;
  localparam int FW = NW + 7;
  localparam int SW = (NW + 1 > vswd_pkg::FRAC_W) ? NW + 1 : vswd_pkg::FRAC_W;

  logic [NW-1:0] num;
  logic [7:0]    raw1_q;
  logic [4:0]    q1_q, q2_q;
  logic [NW-1:0] num1_q;
  logic [BW-1:0] pb1_q;
  logic [PW-1:0] pf1_q;

  logic [7:0]    qb;
  logic [15:0]   prod_b, diff_b;
  logic [NW-1:0] qf;
  logic [FW-1:0] prod_f, diff_f;
  logic [7:0]    qb2_q;
  logic [8:0]    rb2_q;
  logic [NW-1:0] qf2_q;
  logic [7:0]    rf2_q;

  logic          fix_b, fix_f, sat;
  logic [8:0]    remb;
  logic [7:0]    bone;
  logic [SW-1:0] fvx;
  vswd_pkg::lane_res_t res_d, res_q;

  assign num = (NW'(q_i) << WEIGHT_FRAC_BITS) + NW'(total_i >> 1);

  always_ff @(posedge clk_i) begin
    raw1_q <= raw_i;
    q1_q   <= q_i;
    num1_q <= num;
    pb1_q  <= BW'(raw_i) * BW'(rs_i);
    pf1_q  <= PW'(num) * PW'(rt_i);
  end

  assign qb     = pb1_q[vswd_pkg::STRIDE_RECIP_BITS +: 8];
  assign prod_b = 16'(qb) * 16'(stride_i);
  assign diff_b = 16'(raw1_q) - prod_b;
  assign qf     = pf1_q[K +: NW];
  assign prod_f = FW'(qf) * FW'(total_i);
  assign diff_f = FW'(num1_q) - prod_f;

  always_ff @(posedge clk_i) begin
    q2_q  <= q1_q;
    qb2_q <= qb;
    rb2_q <= diff_b[8:0];
    qf2_q <= qf;
    rf2_q <= diff_f[7:0];
  end

  always_comb begin
    fix_b = rb2_q >= {1'b0, stride_i};
    remb  = fix_b ? rb2_q - {1'b0, stride_i} : rb2_q;
    bone  = qb2_q + 8'(fix_b);
    fix_f = rf2_q >= {1'b0, total_i};
    fvx   = SW'(qf2_q) + SW'(fix_f);
    sat   = fvx > SW'(vswd_pkg::FRAC_MAX);

    res_d          = '0;
    res_d.active   = q2_q != '0;
    res_d.aligned  = (stride_i != '0) && (remb == '0);
    res_d.in_range = bone < joint_limit_i;
    res_d.bone     = bone;
    res_d.qweight  = q2_q;
    res_d.frac     = sat ? vswd_pkg::FRAC_MAX : fvx[vswd_pkg::FRAC_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_o = res_q;

endmodule

@@ rtl/vswd_merge.sv @@
// Merge stage: applies the checks in component order and compacts slots.
// Depends on vswd_pkg; fed by the three lanes.
module vswd_merge (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic                sum_ok_i,
  input  logic                topo_i,
  input  vswd_pkg::lane_res_t lane_i [vswd_pkg::NUM_LANES],
  output logic                valid_o,
  output vswd_pkg::out_t      result_o
);

  logic                            stop;
  logic [1:0]                      cnt;
  logic [7:0]                      bone_s [vswd_pkg::NUM_LANES];
  logic [4:0]                      qw_s   [vswd_pkg::NUM_LANES];
  logic [vswd_pkg::FRAC_W-1:0]     fr_s   [vswd_pkg::NUM_LANES];
  vswd_pkg::status_e               status;
  vswd_pkg::out_t                  res_d, res_q;
  logic                            valid_q;

  always_comb begin
    stop   = 1'b0;
    cnt    = '0;
    status = vswd_pkg::ST_OK;
    bone_s = '{default: '0};
    qw_s   = '{default: '0};
    fr_s   = '{default: '0};
    if (!sum_ok_i) begin
      status = vswd_pkg::ST_SUM;
    end else begin
      for (int c = 0; c < vswd_pkg::NUM_LANES; c++) begin
        if (!stop && lane_i[c].active) begin
          if (!lane_i[c].aligned) begin
            status = vswd_pkg::ST_MISALIGN;
            stop   = 1'b1;
          end else if (!lane_i[c].in_range) begin
            status = vswd_pkg::ST_RANGE;
            stop   = 1'b1;
          end else if ((cnt > 2'd0 && lane_i[c].bone == bone_s[0]) ||
                       (cnt > 2'd1 && lane_i[c].bone == bone_s[1])) begin
            status = vswd_pkg::ST_DUP;
            stop   = 1'b1;
          end else begin
            bone_s[cnt] = lane_i[c].bone;
            qw_s[cnt]   = lane_i[c].qweight;
            fr_s[cnt]   = lane_i[c].frac;
            cnt         = cnt + 2'd1;
          end
        end
      end
    end

    res_d                = '0;
    res_d.status         = status;
    res_d.strip_restart  = topo_i;
    res_d.slot_count     = cnt;
    res_d.bone_0         = bone_s[0];
    res_d.bone_1         = bone_s[1];
    res_d.bone_2         = bone_s[2];
    res_d.qweight_0      = qw_s[0];
    res_d.qweight_1      = qw_s[1];
    res_d.qweight_2      = qw_s[2];
    res_d.frac_weight_0  = fr_s[0];
    res_d.frac_weight_1  = fr_s[1];
    res_d.frac_weight_2  = fr_s[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      res_q <= res_d;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = res_q;

endmodule

@@ bench/vertex_skin_weight_decoder_test.sv @@
// Self-checking bench for vertex_skin_weight_decoder: APB register setup, directed and
// random skinning records, each decode predicted and compared field by field.
// Depends on vswd_pkg and the vertex_skin_weight_decoder RTL.
module vertex_skin_weight_decoder_test;
  import vswd_pkg::*;

  localparam int FRAC_BITS    = WEIGHT_FRAC_BITS_DEF;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 8;

  class skin_decode_tracker;
    int unsigned joint_limit;
    int unsigned weight_total;
    int unsigned row_stride;
    out_t        pending_decodes[$];
    int          mismatch_count;

    function new();
      joint_limit    = JOINT_LIMIT_RST;
      weight_total   = WEIGHT_TOTAL_RST;
      row_stride     = ROW_STRIDE_RST;
      mismatch_count = 0;
    endfunction

    function logic [FRAC_W-1:0] frac_of(int unsigned q);
      longint unsigned v;
      if (weight_total == 0) return '0;
      v = ((longint'(q) << FRAC_BITS) + weight_total / 2) / weight_total;
      if (v > FRAC_MAX) v = FRAC_MAX;
      return v[FRAC_W-1:0];
    endfunction

    function out_t decode_record(in_t it);
      out_t              r;
      int unsigned       q [3];
      int unsigned       offs [3];
      logic [7:0]        bones [3];
      logic [4:0]        qs [3];
      logic [FRAC_W-1:0] fr [3];
      int unsigned       count;
      int unsigned       bone;
      int unsigned       sum;
      bit                dup;
      int                c;
      int                k;
      r     = '0;
      bones = '{default: '0};
      qs    = '{default: '0};
      fr    = '{default: '0};
      count = 0;
      q[0] = it.packed_word[4:0];
      q[1] = it.packed_word[9:5];
      q[2] = it.packed_word[14:10];
      offs[0] = it.blend_index_1;
      offs[1] = it.blend_index_2;
      offs[2] = it.blend_index_3;
      sum = q[0] + q[1] + q[2];
      r.strip_restart = it.packed_word[15];
      r.status = ST_OK;
      if (sum != weight_total) begin
        r.status = ST_SUM;
      end else begin
        for (c = 0; c < 3; c++) begin
          if (q[c] == 0) continue;
          if (row_stride == 0 || (offs[c] % row_stride) != 0) begin
            r.status = ST_MISALIGN;
            break;
          end
          bone = offs[c] / row_stride;
          if (bone >= joint_limit) begin
            r.status = ST_RANGE;
            break;
          end
          dup = 1'b0;
          for (k = 0; k < count; k++) if (bones[k] == bone) dup = 1'b1;
          if (dup) begin
            r.status = ST_DUP;
            break;
          end
          bones[count] = bone[7:0];
          qs[count]    = q[c][4:0];
          fr[count]    = frac_of(q[c]);
          count++;
        end
      end
      r.slot_count = 2'(count);
      r.bone_0 = bones[0];
      r.bone_1 = bones[1];
      r.bone_2 = bones[2];
      r.qweight_0 = qs[0];
      r.qweight_1 = qs[1];
      r.qweight_2 = qs[2];
      r.frac_weight_0 = fr[0];
      r.frac_weight_1 = fr[1];
      r.frac_weight_2 = fr[2];
      return r;
    endfunction

    function void note_record(in_t it);
      pending_decodes.push_back(decode_record(it));
    endfunction

    task report_mismatch(string msg);
      $display("mismatch: %s", msg);
      mismatch_count++;
    endtask

    task compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    task check_decode(out_t got);
      out_t want;
      if (pending_decodes.size() == 0) begin
        report_mismatch("result strobe with no record pending");
        return;
      end
      want = pending_decodes.pop_front();
      compare_field("status", got.status, want.status);
      compare_field("strip_restart", got.strip_restart, want.strip_restart);
      compare_field("slot_count", got.slot_count, want.slot_count);
      compare_field("bone_0", got.bone_0, want.bone_0);
      compare_field("bone_1", got.bone_1, want.bone_1);
      compare_field("bone_2", got.bone_2, want.bone_2);
      compare_field("qweight_0", got.qweight_0, want.qweight_0);
      compare_field("qweight_1", got.qweight_1, want.qweight_1);
      compare_field("qweight_2", got.qweight_2, want.qweight_2);
      compare_field("frac_weight_0", got.frac_weight_0, want.frac_weight_0);
      compare_field("frac_weight_1", got.frac_weight_1, want.frac_weight_1);
      compare_field("frac_weight_2", got.frac_weight_2, want.frac_weight_2);
    endtask
  endclass

  logic                clk_i   = 1'b0;
  logic                rst_ni  = 1'b0;
  logic                start   = 1'b0;
  in_t                 item_i  = '0;
  logic                psel    = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite  = 1'b0;
  logic [ADDR_W-1:0]   paddr   = '0;
  logic [DATA_W-1:0]   pwdata  = '0;
  logic                busy;
  logic                result_valid_o;
  out_t                result_o;
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  int unsigned         cycle_count = 0;

  skin_decode_tracker tracker = new();

  vertex_skin_weight_decoder dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .item_i         (item_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) tracker.check_decode(result_o);
  end

  task automatic write_reg(reg_idx_e idx, int unsigned value);
    while (busy) @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= DATA_W'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_JOINT_LIMIT:  tracker.joint_limit  = value & 32'hFF;
      REG_WEIGHT_TOTAL: tracker.weight_total = value & 32'h7F;
      REG_ROW_STRIDE:   tracker.row_stride   = value & 32'hFF;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (tracker.pending_decodes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic configure(int unsigned nc, int unsigned wt, int unsigned rs);
    drain();
    write_reg(REG_JOINT_LIMIT, nc);
    write_reg(REG_WEIGHT_TOTAL, wt);
    write_reg(REG_ROW_STRIDE, rs);
  endtask

  task automatic send_record(in_t it, int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start  <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
    tracker.note_record(it);
  endtask

  function automatic in_t record_of(int unsigned o1, int unsigned o2, int unsigned o3,
                                    bit topo, int unsigned q0, int unsigned q1,
                                    int unsigned q2);
    in_t it;
    it.blend_index_1 = o1[7:0];
    it.blend_index_2 = o2[7:0];
    it.blend_index_3 = o3[7:0];
    it.packed_word   = {topo, q2[4:0], q1[4:0], q0[4:0]};
    return it;
  endfunction

  function automatic in_t random_record();
    logic [39:0] noise;
    int unsigned mode, rem, lo, hi, maxb, pick, other, tmp;
    int unsigned perm [3];
    int unsigned q [3];
    int unsigned offs [3];
    int unsigned bones [3];
    bit          has_bones;
    int          k, c, tries;
    mode = $urandom_range(99);
    if (mode < 25 || tracker.weight_total > 93) begin
      noise = {$urandom, 8'($urandom)};
      return noise;
    end
    perm = '{0, 1, 2};
    for (k = 2; k > 0; k--) begin
      pick = $urandom_range(k);
      tmp = perm[k];
      perm[k] = perm[pick];
      perm[pick] = tmp;
    end
    rem = tracker.weight_total;
    for (k = 0; k < 3; k++) begin
      lo = (rem > 31 * (2 - k)) ? rem - 31 * (2 - k) : 0;
      hi = (rem < 31) ? rem : 31;
      q[perm[k]] = $urandom_range(hi, lo);
      rem -= q[perm[k]];
    end
    has_bones = tracker.row_stride != 0 && tracker.joint_limit != 0;
    maxb = 0;
    if (has_bones) begin
      maxb = 255 / tracker.row_stride;
      if (tracker.joint_limit - 1 < maxb) maxb = tracker.joint_limit - 1;
    end
    for (c = 0; c < 3; c++) begin
      bones[c] = $urandom_range(maxb);
      for (tries = 0; tries < 4; tries++)
        if ((c > 0 && bones[c] == bones[0]) || (c == 2 && bones[c] == bones[1]))
          bones[c] = $urandom_range(maxb);
      offs[c] = has_bones ? bones[c] * tracker.row_stride : $urandom_range(255);
      if (q[c] == 0 && $urandom_range(1)) offs[c] = $urandom_range(255);
    end
    if (mode < 45) begin
      pick  = $urandom_range(2);
      other = (pick + 1 + $urandom_range(1)) % 3;
      case ($urandom_range(3))
        0: offs[pick] = (offs[pick] + 1) % 256;
        1: begin
          tmp = tracker.row_stride * (tracker.joint_limit + $urandom_range(3));
          offs[pick] = (tmp > 255) ? 255 : tmp;
        end
        2: offs[pick] = offs[other];
        default: q[pick] = (q[pick] + 1) % 32;
      endcase
    end
    return record_of(offs[0], offs[1], offs[2], 1'($urandom), q[0], q[1], q[2]);
  endfunction

  task automatic run_random(int n, int idle_pct);
    repeat (n) send_record(random_record(), idle_pct);
  endtask

  initial begin
    int idle_modes [3];
    int p;
    idle_modes = '{0, 80, 31};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    configure(85, 31, 3);
    send_record(record_of(0, 0, 0, 0, 0, 0, 0), 0);
    send_record(record_of(255, 255, 255, 1, 31, 31, 31), 0);
    send_record(record_of(0, 0, 0, 0, 31, 0, 0), 0);
    send_record(record_of(3, 6, 9, 0, 10, 10, 11), 0);
    send_record(record_of(4, 0, 0, 0, 31, 0, 0), 0);
    send_record(record_of(255, 0, 0, 0, 31, 0, 0), 0);
    send_record(record_of(6, 6, 0, 0, 15, 16, 0), 0);
    send_record(record_of(1, 3, 1, 1, 0, 31, 0), 0);
    send_record(record_of(3, 6, 3, 0, 10, 10, 11), 0);
    send_record(record_of(0, 0, 252, 1, 0, 0, 31), 0);
    send_record(record_of(3, 4, 9, 0, 10, 10, 11), 0);
    send_record(record_of(3, 6, 255, 0, 10, 10, 11), 0);
    run_random(40, 0);

    configure(255, 93, 1);
    send_record(record_of(0, 1, 2, 0, 31, 31, 31), 0);
    send_record(record_of(254, 255, 0, 1, 31, 31, 31), 0);
    run_random(50, 80);

    configure(0, 31, 3);
    send_record(record_of(0, 3, 6, 0, 10, 10, 11), 0);
    send_record(record_of(0, 0, 0, 1, 0, 0, 0), 0);
    run_random(30, 31);

    configure(10, 0, 3);
    send_record(record_of(1, 2, 4, 1, 0, 0, 0), 0);
    send_record(record_of(0, 0, 0, 0, 1, 0, 0), 0);
    run_random(30, 0);

    configure(10, 31, 0);
    send_record(record_of(0, 0, 0, 0, 31, 0, 0), 0);
    run_random(30, 80);

    configure(40, 127, 2);
    send_record(record_of(0, 2, 4, 0, 31, 31, 31), 0);
    run_random(20, 31);

    configure(255, 1, 255);
    run_random(50, 0);

    for (p = 0; p < 6; p++) begin
      configure($urandom_range(255), $urandom_range(93, 1),
                $urandom_range((p % 2) ? 255 : 8, 1));
      run_random(50, idle_modes[p % 3]);
    end

    drain();
    if (tracker.mismatch_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule

@@ sim.f @@
rtl/vswd_pkg.sv
rtl/vswd_recip.sv
rtl/vswd_lane.sv
rtl/vswd_merge.sv
rtl/vertex_skin_weight_decoder.sv
bench/vertex_skin_weight_decoder_test.sv
